### sv/srsg_pkg.sv
// ----------------------------------------------------------------------------
// srsg_pkg
// Shared widths, constants, control-store contents and helpers of the
// stepper ramp segment generator.
// ----------------------------------------------------------------------------
package srsg_pkg;

  localparam int unsigned EXP_LEVELS_DEF = 8;

  localparam int unsigned STEPS_W = 21;
  localparam int unsigned SPEED_W = 12;
  localparam int unsigned MINSP_W = 10;
  localparam int unsigned N_W     = 6;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned REM_W   = STEPS_W + 1;
  localparam int unsigned SQ_W    = 2 * SPEED_W;
  localparam int unsigned X_W     = 5;
  localparam int unsigned PROD_W  = 25;

  localparam logic [SPEED_W-1:0] SPEED_MAX     = 12'd3199;
  localparam logic [MINSP_W-1:0] MIN_SPEED_RST = 10'd50;

  localparam int unsigned ACCEL_RATE  = 5000;
  localparam int unsigned UPDATE_FREQ = 100;
  localparam int unsigned RUNG_SPEED  = 50;
  localparam int unsigned EST_DIV     = 2 * ACCEL_RATE;
  localparam logic [13:0] EST_DIV_C   = 14'(EST_DIV);

  // Largest estimate is 3199^2/10000 = 1023; any |steps| at or above never loses.
  localparam int unsigned EST_ABS_LIM = 1023;

  // 5243/2^18 ~ 1/RUNG_SPEED and 5243/2^19 ~ 1/UPDATE_FREQ, exact for 12-bit values.
  localparam logic [12:0] RECIP   = 13'd5243;
  localparam int unsigned N_SHIFT = 18;
  localparam int unsigned X_SHIFT = 19;

  // Control store addresses
  localparam int unsigned PC_W = 4;
  localparam logic [PC_W-1:0] P_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] P_SQ    = 4'd1;
  localparam logic [PC_W-1:0] P_CHK   = 4'd2;
  localparam logic [PC_W-1:0] P_BR    = 4'd3;
  localparam logic [PC_W-1:0] P_DIVW  = 4'd4;
  localparam logic [PC_W-1:0] P_LINIT = 4'd5;
  localparam logic [PC_W-1:0] P_RV    = 4'd6;
  localparam logic [PC_W-1:0] P_RX    = 4'd7;
  localparam logic [PC_W-1:0] P_REMIT = 4'd8;
  localparam logic [PC_W-1:0] P_FINAL = 4'd9;
  localparam logic [PC_W-1:0] P_FCALC = 4'd10;
  localparam logic [PC_W-1:0] P_FEMIT = 4'd11;
  localparam logic [PC_W-1:0] P_DONE  = 4'd12;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SQ,
    OP_CHK,
    OP_DIV_START,
    OP_LIN_INIT,
    OP_RUNG_V,
    OP_RUNG_X,
    OP_RUNG_EMIT,
    OP_FINAL,
    OP_FB_CALC,
    OP_FB_EMIT,
    OP_DONE
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_START,
    C_FB,
    C_DIV_BUSY,
    C_MORE_RUNGS,
    C_MORE_LVLS
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      P_IDLE:  w = '{OP_LOAD,      C_NO_START,   P_IDLE};
      P_SQ:    w = '{OP_SQ,        C_NEXT,       P_IDLE};
      P_CHK:   w = '{OP_CHK,       C_NEXT,       P_IDLE};
      P_BR:    w = '{OP_DIV_START, C_FB,         P_FCALC};
      P_DIVW:  w = '{OP_NOP,       C_DIV_BUSY,   P_DIVW};
      P_LINIT: w = '{OP_LIN_INIT,  C_NEXT,       P_IDLE};
      P_RV:    w = '{OP_RUNG_V,    C_NEXT,       P_IDLE};
      P_RX:    w = '{OP_RUNG_X,    C_NEXT,       P_IDLE};
      P_REMIT: w = '{OP_RUNG_EMIT, C_MORE_RUNGS, P_RV};
      P_FINAL: w = '{OP_FINAL,     C_ALWAYS,     P_DONE};
      P_FCALC: w = '{OP_FB_CALC,   C_NEXT,       P_IDLE};
      P_FEMIT: w = '{OP_FB_EMIT,   C_MORE_LVLS,  P_FCALC};
      P_DONE:  w = '{OP_DONE,      C_ALWAYS,     P_IDLE};
      default: w = '{OP_NOP,       C_ALWAYS,     P_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [REM_W-1:0] mag(input logic signed [REM_W-1:0] v);
    return v[REM_W-1] ? REM_W'(-v) : REM_W'(v);
  endfunction

  function automatic logic [SPEED_W-1:0] spd_floor(input logic [SPEED_W-1:0] v,
                                                   input logic [MINSP_W-1:0] mn);
    return (v < SPEED_W'(mn)) ? SPEED_W'(mn) : v;
  endfunction

endpackage

### sv/stepper_ramp_segment_generator.sv
// ----------------------------------------------------------------------------
// stepper_ramp_segment_generator
// Busy while a command runs: on the linear profile through n = speed/50
// rungs, three control steps per rung, six single steps, and a divide of speed
// by n that holds the sequencer until the divider is done, and on the
// power-of-two profile through its EXP_LEVELS levels. Each segment leaves in
// the cycle after the next is formed; the last strobes in the first cycle with
// busy low. A new command is taken as soon as busy is low. The receiver cannot stall.
// Reset returns the sequencer to idle, drops any held segment, sets min_speed to 50.
// ----------------------------------------------------------------------------
module stepper_ramp_segment_generator #(
  parameter int unsigned EXP_LEVELS = srsg_pkg::EXP_LEVELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [srsg_pkg::STEPS_W-1:0] ramp_steps_i,
  input  logic        [srsg_pkg::SPEED_W-1:0] target_speed_i,
  input  logic                                decelerate_i,
  input  logic                                rotate_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic        [srsg_pkg::MINSP_W-1:0] cfg_data_i,
  output logic                                segment_valid_o,
  output logic signed [srsg_pkg::STEPS_W-1:0] segment_steps_o,
  output logic        [srsg_pkg::SPEED_W-1:0] segment_speed_o,
  output logic                                is_rotation_o,
  output logic                                used_fallback_o,
  output logic                                last_segment_o
);

  localparam int unsigned STEPS_W = srsg_pkg::STEPS_W;
  localparam int unsigned SPEED_W = srsg_pkg::SPEED_W;
  localparam int unsigned MINSP_W = srsg_pkg::MINSP_W;
  localparam int unsigned N_W     = srsg_pkg::N_W;
  localparam int unsigned IDX_W   = srsg_pkg::IDX_W;
  localparam int unsigned REM_W   = srsg_pkg::REM_W;
  localparam int unsigned SQ_W    = srsg_pkg::SQ_W;
  localparam int unsigned X_W     = srsg_pkg::X_W;
  localparam int unsigned PROD_W  = srsg_pkg::PROD_W;
  localparam int unsigned PC_W    = srsg_pkg::PC_W;

  localparam logic [IDX_W-1:0] LVL_LAST = IDX_W'(EXP_LEVELS - 1);
  localparam logic [IDX_W-1:0] LVL_NUM  = IDX_W'(EXP_LEVELS);

  // Sequencer
  logic [PC_W-1:0]  pc_q, pc_d;
  srsg_pkg::uword_t uw;
  logic             jump;

  // Command and datapath registers
  logic [MINSP_W-1:0]       min_speed_q;
  logic signed [STEPS_W-1:0] steps_q, steps_d;
  logic [STEPS_W-1:0]       abs_q, abs_d;
  logic [SPEED_W-1:0]       speed_q, speed_d;
  logic                     decel_q, decel_d;
  logic                     rot_q, rot_d;
  logic [N_W-1:0]           n_q, n_d;
  logic [SQ_W-1:0]          sq_q, sq_d;
  logic [SQ_W-1:0]          thr_q, thr_d;
  logic                     fb_q, fb_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [SPEED_W-1:0]       part_q, part_d;
  logic [N_W-1:0]           frac_q, frac_d;
  logic [SPEED_W-1:0]       v_q, v_d;
  logic [X_W-1:0]           x_q, x_d;
  logic signed [REM_W-1:0]  it_q, it_d;
  logic [SPEED_W-1:0]       sp_q, sp_d;
  logic signed [REM_W-1:0]  rem_q, rem_d;

  // Segment hold and output stage
  logic                      pend_vld_q, pend_vld_d;
  logic signed [STEPS_W-1:0] pend_steps_q;
  logic [SPEED_W-1:0]        pend_speed_q;
  logic                      pend_fb_q;
  logic                      seg_vld_q, seg_vld_d;
  logic signed [STEPS_W-1:0] seg_steps_q;
  logic [SPEED_W-1:0]        seg_speed_q;
  logic                      seg_rot_q;
  logic                      seg_fb_q;
  logic                      seg_last_q;

  logic                     push_en;
  logic signed [REM_W-1:0]  push_steps;
  logic [SPEED_W-1:0]       push_speed;
  logic                     push_fb;
  logic                     done_en;

  // Divider
  logic               div_start;
  logic               div_busy;
  logic [SPEED_W-1:0] div_quo;
  logic [N_W-1:0]     div_rem;

  // Combinational helpers
  logic signed [REM_W-1:0]  in_ext;
  logic [REM_W-1:0]         in_mag;
  logic [PROD_W-1:0]        prod_n;
  logic [PROD_W-1:0]        prod_x;
  logic [X_W-1:0]           xq;
  logic signed [REM_W-1:0]  x_ext;
  logic signed [REM_W-1:0]  xs;
  logic [N_W:0]             fsum;
  logic                     carry;
  logic [IDX_W-1:0]         dsh;
  logic signed [REM_W-1:0]  steps_ext;
  logic signed [REM_W-1:0]  bias;
  logic signed [REM_W-1:0]  biased;
  logic signed [REM_W-1:0]  quot;
  logic [REM_W-1:0]         rem_mag;

  srsg_div #(
    .DIVIDEND_W (SPEED_W),
    .DIVISOR_W  (N_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (speed_q),
    .divisor_i   (n_q),
    .busy_o      (div_busy),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Control store and next step
  always_comb begin
    uw = srsg_pkg::ucode(pc_q);
    unique case (uw.cond)
      srsg_pkg::C_NEXT:       jump = 1'b0;
      srsg_pkg::C_ALWAYS:     jump = 1'b1;
      srsg_pkg::C_NO_START:   jump = !start;
      srsg_pkg::C_FB:         jump = fb_q;
      srsg_pkg::C_DIV_BUSY:   jump = div_busy;
      srsg_pkg::C_MORE_RUNGS: jump = idx_q != IDX_W'(n_q - N_W'(1));
      srsg_pkg::C_MORE_LVLS:  jump = idx_q != LVL_LAST;
      default:                jump = 1'b0;
    endcase
    pc_d = jump ? uw.target : pc_q + PC_W'(1);
  end

  // Shared arithmetic
  always_comb begin
    in_ext    = REM_W'(ramp_steps_i);
    in_mag    = srsg_pkg::mag(in_ext);
    prod_n    = PROD_W'(speed_q) * PROD_W'(srsg_pkg::RECIP);
    prod_x    = PROD_W'(v_q) * PROD_W'(srsg_pkg::RECIP);
    xq        = prod_x[srsg_pkg::X_SHIFT+X_W-1:srsg_pkg::X_SHIFT];
    x_ext     = signed'(REM_W'(x_q));
    xs        = steps_q[STEPS_W-1] ? -x_ext : x_ext;
    fsum      = {1'b0, frac_q} + {1'b0, div_rem};
    carry     = fsum >= {1'b0, n_q};
    rem_mag   = srsg_pkg::mag(rem_q);
    dsh       = decel_q ? (idx_q + IDX_W'(1)) : (LVL_NUM - idx_q);
    steps_ext = REM_W'(steps_q);
    // round toward zero: bias negative values by 2^d - 1 before the shift
    bias      = steps_q[STEPS_W-1] ? signed'((REM_W'(1) << dsh) - REM_W'(1)) : '0;
    biased    = steps_ext + bias;
    quot      = biased >>> dsh;
  end

  // Datapath actions per control word
  always_comb begin
    steps_d    = steps_q;
    abs_d      = abs_q;
    speed_d    = speed_q;
    decel_d    = decel_q;
    rot_d      = rot_q;
    n_d        = n_q;
    sq_d       = sq_q;
    thr_d      = thr_q;
    fb_d       = fb_q;
    idx_d      = idx_q;
    part_d     = part_q;
    frac_d     = frac_q;
    v_d        = v_q;
    x_d        = x_q;
    it_d       = it_q;
    sp_d       = sp_q;
    rem_d      = rem_q;
    push_en    = 1'b0;
    push_steps = it_q;
    push_speed = sp_q;
    push_fb    = 1'b0;
    done_en    = 1'b0;
    div_start  = 1'b0;

    unique case (uw.op)
      srsg_pkg::OP_NOP: begin
      end
      srsg_pkg::OP_LOAD: begin
        if (start) begin
          steps_d = ramp_steps_i;
          abs_d   = in_mag[STEPS_W-1:0];
          speed_d = (target_speed_i > srsg_pkg::SPEED_MAX) ? srsg_pkg::SPEED_MAX
                                                           : target_speed_i;
          decel_d = decelerate_i;
          rot_d   = rotate_i;
          rem_d   = in_ext;
        end
      end
      srsg_pkg::OP_SQ: begin
        sq_d  = SQ_W'(speed_q) * SQ_W'(speed_q);
        n_d   = prod_n[srsg_pkg::N_SHIFT+N_W-1:srsg_pkg::N_SHIFT];
        thr_d = SQ_W'(srsg_pkg::EST_DIV_C) * SQ_W'(11'(abs_q[9:0]) + 11'd1);
        idx_d = '0;
      end
      srsg_pkg::OP_CHK: begin
        fb_d = (n_q == '0)
            || ((abs_q < STEPS_W'(srsg_pkg::EST_ABS_LIM)) && (sq_q >= thr_q));
      end
      srsg_pkg::OP_DIV_START: begin
        div_start = !fb_q;
      end
      srsg_pkg::OP_LIN_INIT: begin
        part_d = '0;
        frac_d = '0;
        idx_d  = '0;
      end
      srsg_pkg::OP_RUNG_V: begin
        v_d = srsg_pkg::spd_floor(decel_q ? (speed_q - part_q) : part_q, min_speed_q);
      end
      srsg_pkg::OP_RUNG_X: begin
        x_d = (xq == '0) ? X_W'(1) : xq;
      end
      srsg_pkg::OP_RUNG_EMIT: begin
        if (rem_mag >= REM_W'(x_q)) begin
          rem_d      = rem_q - xs;
          push_en    = 1'b1;
          push_steps = xs;
          push_speed = v_q;
        end
        // advance i*speed/n: whole quotient plus a carry from the remainder
        frac_d = carry ? N_W'(fsum - {1'b0, n_q}) : fsum[N_W-1:0];
        part_d = part_q + div_quo + SPEED_W'(carry);
        idx_d  = idx_q + IDX_W'(1);
      end
      srsg_pkg::OP_FINAL: begin
        if (rem_q != '0) begin
          push_en    = 1'b1;
          push_steps = rem_q;
          push_speed = srsg_pkg::spd_floor(decel_q ? div_quo : speed_q, min_speed_q);
        end
      end
      srsg_pkg::OP_FB_CALC: begin
        it_d = (idx_q == LVL_LAST) ? rem_q : quot;
        sp_d = srsg_pkg::spd_floor(speed_q >> dsh, min_speed_q);
      end
      srsg_pkg::OP_FB_EMIT: begin
        if ((it_q != '0) && (rem_mag >= srsg_pkg::mag(it_q))) begin
          rem_d      = rem_q - it_q;
          push_en    = 1'b1;
          push_steps = it_q;
          push_speed = sp_q;
          push_fb    = 1'b1;
        end
        idx_d = idx_q + IDX_W'(1);
      end
      srsg_pkg::OP_DONE: begin
        done_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Hold one segment back so the final one can carry its last flag
  always_comb begin
    pend_vld_d = pend_vld_q;
    seg_vld_d  = 1'b0;
    if (push_en) begin
      pend_vld_d = 1'b1;
      seg_vld_d  = pend_vld_q;
    end else if (done_en) begin
      pend_vld_d = 1'b0;
      seg_vld_d  = pend_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= srsg_pkg::P_IDLE;
      min_speed_q <= srsg_pkg::MIN_SPEED_RST;
      pend_vld_q  <= 1'b0;
      seg_vld_q   <= 1'b0;
    end else begin
      pc_q       <= pc_d;
      pend_vld_q <= pend_vld_d;
      seg_vld_q  <= seg_vld_d;
      if (cfg_valid_i) begin
        min_speed_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    steps_q <= steps_d;
    abs_q   <= abs_d;
    speed_q <= speed_d;
    decel_q <= decel_d;
    rot_q   <= rot_d;
    n_q     <= n_d;
    sq_q    <= sq_d;
    thr_q   <= thr_d;
    fb_q    <= fb_d;
    idx_q   <= idx_d;
    part_q  <= part_d;
    frac_q  <= frac_d;
    v_q     <= v_d;
    x_q     <= x_d;
    it_q    <= it_d;
    sp_q    <= sp_d;
    rem_q   <= rem_d;
    if (push_en || done_en) begin
      seg_steps_q <= pend_steps_q;
      seg_speed_q <= pend_speed_q;
      seg_rot_q   <= rot_q;
      seg_fb_q    <= pend_fb_q;
      seg_last_q  <= done_en;
    end
    if (push_en) begin
      pend_steps_q <= push_steps[STEPS_W-1:0];
      pend_speed_q <= push_speed;
      pend_fb_q    <= push_fb;
    end
  end

  assign busy            = pc_q != srsg_pkg::P_IDLE;
  assign cfg_ready_o     = 1'b1;
  assign segment_valid_o = seg_vld_q;
  assign segment_steps_o = seg_steps_q;
  assign segment_speed_o = seg_speed_q;
  assign is_rotation_o   = seg_rot_q;
  assign used_fallback_o = seg_fb_q;
  assign last_segment_o  = seg_last_q;

  a_seg_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    segment_valid_o |-> $past(busy))
    else $error("segment strobe without a command in progress");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_last_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (segment_valid_o && last_segment_o) |=> !segment_valid_o)
    else $error("segment strobe after the last segment");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !pend_vld_q)
    else $error("held segment left behind at idle");

endmodule

### sv/srsg_div.sv
// ----------------------------------------------------------------------------
// srsg_div
// Restoring divider, one quotient bit per cycle; quotient and remainder
// hold after busy falls until the next start.
// ----------------------------------------------------------------------------
module srsg_div #(
  parameter int unsigned DIVIDEND_W = srsg_pkg::SPEED_W,
  parameter int unsigned DIVISOR_W  = srsg_pkg::N_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  busy_o,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output logic [DIVISOR_W-1:0]  remainder_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dvs_q;

  logic [DIVISOR_W:0]    trial;
  logic                  ge;
  logic [DIVISOR_W:0]    diff;

  always_comb begin
    trial = {rem_q, quo_q[DIVIDEND_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    diff  = ge ? (trial - {1'b0, dvs_q}) : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DIVIDEND_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
      rem_q <= diff[DIVISOR_W-1:0];
    end
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule
